// ----- src/sfa_pkg.sv -----
`timescale 1ns / 1ps
package sfa_pkg;

    localparam int SQRT_STEPS = 8;
    localparam int SQ_CW      = $clog2(SQRT_STEPS + 1);

    localparam logic [31:0] UPPER_RST = 32'h7149_F2CA;
    localparam logic [31:0] LOWER_RST = 32'hF149_F2CA;
    localparam logic [31:0] EPS_RST   = 32'h3586_37BD;
    localparam logic [31:0] F_ZERO    = 32'h0000_0000;
    localparam logic [31:0] F_TEN     = 32'h4120_0000;
    localparam logic [31:0] F_HALF    = 32'h3F00_0000;
    localparam logic [31:0] F_DEFNAN  = 32'hFFC0_0000;
    localparam logic [31:0] F_QBIT    = 32'h0040_0000;

    typedef enum logic [1:0] {
        CFG_UPPER = 2'd0,
        CFG_LOWER = 2'd1,
        CFG_EPS   = 2'd2
    } t_cfg_idx;

    typedef enum logic [4:0] {
        OP_ADD      = 5'd0,
        OP_SUB      = 5'd1,
        OP_MUL      = 5'd2,
        OP_DIV      = 5'd3,
        OP_SQRT     = 5'd4,
        OP_SQUARE   = 5'd5,
        OP_MIN      = 5'd6,
        OP_MAX      = 5'd7,
        OP_CLAMP    = 5'd8,
        OP_ABS      = 5'd9,
        OP_SANITIZE = 5'd10,
        OP_IS_SAFE  = 5'd11,
        OP_IS_ZERO  = 5'd12,
        OP_EQ       = 5'd13,
        OP_LT       = 5'd14,
        OP_LE       = 5'd15,
        OP_GT       = 5'd16,
        OP_GE       = 5'd17
    } t_req_op;

    typedef enum logic [1:0] {
        FOP_ADD,
        FOP_SUB,
        FOP_MUL,
        FOP_DIV
    } t_fop;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SETUP,
        F_PRE,
        F_DIV,
        F_DVEND,
        F_NORM,
        F_ROUND,
        F_DONE
    } t_fstate;

    typedef enum logic [4:0] {
        S_IDLE,
        S_H,
        S_L,
        S_LSV,
        S_CA,
        S_CB,
        S_CC,
        S_DISP,
        S_WAIT,
        S_FINC,
        S_FINS,
        S_EQA,
        S_EQB,
        S_EQS,
        S_EQF,
        S_CMPF,
        S_SQT,
        S_SQADD,
        S_SQHALF,
        S_SQDIFF,
        S_SQCHK,
        S_SQE,
        S_OUT
    } t_state;

    function automatic logic f_is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic f_is_inf(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    endfunction

    function automatic logic f_is_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    // a < b, IEEE semantics
    function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
        logic res;
        if (f_is_nan(a) || f_is_nan(b) || (f_is_zero(a) && f_is_zero(b))) begin
            res = 1'b0;
        end else if (a[31] != b[31]) begin
            res = a[31];
        end else if (!a[31]) begin
            res = a[30:0] < b[30:0];
        end else begin
            res = a[30:0] > b[30:0];
        end
        return res;
    endfunction

    function automatic logic f_eq(input logic [31:0] a, input logic [31:0] b);
        return !f_is_nan(a) && !f_is_nan(b) &&
               ((a == b) || (f_is_zero(a) && f_is_zero(b)));
    endfunction

    function automatic logic f_near_zero(input logic [31:0] x, input logic [31:0] eps);
        return f_lt({~eps[31], eps[30:0]}, x) && f_lt(x, eps);
    endfunction

    function automatic logic [31:0] f_sat(input logic [31:0] r, input logic [31:0] hi,
                                          input logic [31:0] lo, input logic [31:0] eps);
        logic [31:0] res;
        if (f_lt(hi, r)) begin
            res = hi;
        end else if (f_lt(r, lo)) begin
            res = lo;
        end else if (f_near_zero(r, eps)) begin
            res = F_ZERO;
        end else begin
            res = r;
        end
        return res;
    endfunction

    // h and l are the limits times ten
    function automatic logic [31:0] f_clean(input logic [31:0] x, input logic [31:0] hi,
                                            input logic [31:0] lo, input logic [31:0] eps,
                                            input logic [31:0] h, input logic [31:0] l);
        logic [31:0] res;
        if (f_is_nan(x)) begin
            res = F_ZERO;
        end else if (f_lt(h, x) || f_lt(x, l)) begin
            res = f_lt(F_ZERO, x) ? hi : lo;
        end else begin
            res = f_sat(x, hi, lo, eps);
        end
        return res;
    endfunction

endpackage

// ----- src/sfa_req_if.sv -----
`timescale 1ns / 1ps
interface sfa_req_if;
    logic        valid;
    logic        ready;
    logic [4:0]  req_type;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] operand_c;

    modport source (output valid, output req_type, output operand_a, output operand_b,
                    output operand_c, input ready);
    modport sink (input valid, input req_type, input operand_a, input operand_b,
                  input operand_c, output ready);
endinterface

// ----- src/sfa_rsp_if.sv -----
`timescale 1ns / 1ps
interface sfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_out;
    logic        truth_out;

    modport source (output valid, output value_out, output truth_out, input ready);
    modport sink (input valid, input value_out, input truth_out, output ready);
endinterface

// ----- src/sfa_fpu.sv -----
`timescale 1ns / 1ps
module sfa_fpu import sfa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_fop        i_op,
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    output logic        o_done,
    output logic [31:0] o_res
);

    localparam int QBITS = 27;
    localparam int QCW   = $clog2(QBITS);

    t_fstate            r_fst, n_fst;
    t_fop               r_op, n_op;
    logic [31:0]        r_x, n_x, r_y, n_y, r_res, n_res;
    logic               r_s, n_s, r_stk, n_stk;
    logic signed [11:0] r_e, n_e, r_ea, n_ea, r_eb, n_eb;
    logic [51:0]        r_m, n_m;
    logic [23:0]        r_ma, n_ma, r_mb, n_mb;
    logic [24:0]        r_rem, n_rem;
    logic [QBITS-1:0]   r_q, n_q;
    logic [QCW-1:0]     r_cnt, n_cnt;

    logic        w_sy, w_xbig, w_sp, w_bs, w_stk, w_ge, w_g, w_st, w_inc;
    logic [31:0] w_sp_res, w_rnd;
    logic [7:0]  w_ex, w_ey, w_eb8, w_es8, w_d;
    logic [23:0] w_mx, w_my, w_mbig, w_msml, w_mant, w_rm;
    logic [26:0] w_ext, w_shf;
    logic [27:0] w_sum;
    logic [47:0] w_prod;
    logic [24:0] w_rdiff, w_rs;
    logic signed [11:0] w_re;

    always_comb begin
        w_sy  = r_y[31] ^ (r_op == FOP_SUB);
        w_ex  = (r_x[30:23] == 8'd0) ? 8'd1 : r_x[30:23];
        w_ey  = (r_y[30:23] == 8'd0) ? 8'd1 : r_y[30:23];
        w_mx  = {r_x[30:23] != 8'd0, r_x[22:0]};
        w_my  = {r_y[30:23] != 8'd0, r_y[22:0]};

        // special operands
        w_sp     = 1'b1;
        w_sp_res = F_DEFNAN;
        if (f_is_nan(r_x)) begin
            w_sp_res = r_x | F_QBIT;
        end else if (f_is_nan(r_y)) begin
            w_sp_res = r_y | F_QBIT;
        end else begin
            unique case (r_op)
                FOP_ADD, FOP_SUB: begin
                    if (f_is_inf(r_x) && f_is_inf(r_y) && (r_x[31] != w_sy)) begin
                        w_sp_res = F_DEFNAN;
                    end else if (f_is_inf(r_x)) begin
                        w_sp_res = r_x;
                    end else if (f_is_inf(r_y)) begin
                        w_sp_res = {w_sy, 8'hFF, 23'd0};
                    end else begin
                        w_sp = 1'b0;
                    end
                end
                FOP_MUL: begin
                    if ((f_is_inf(r_x) && f_is_zero(r_y)) ||
                        (f_is_zero(r_x) && f_is_inf(r_y))) begin
                        w_sp_res = F_DEFNAN;
                    end else if (f_is_inf(r_x) || f_is_inf(r_y)) begin
                        w_sp_res = {r_x[31] ^ r_y[31], 8'hFF, 23'd0};
                    end else if (f_is_zero(r_x) || f_is_zero(r_y)) begin
                        w_sp_res = {r_x[31] ^ r_y[31], 31'd0};
                    end else begin
                        w_sp = 1'b0;
                    end
                end
                FOP_DIV: begin
                    if ((f_is_inf(r_x) && f_is_inf(r_y)) ||
                        (f_is_zero(r_x) && f_is_zero(r_y))) begin
                        w_sp_res = F_DEFNAN;
                    end else if (f_is_inf(r_x) || f_is_zero(r_y)) begin
                        w_sp_res = {r_x[31] ^ r_y[31], 8'hFF, 23'd0};
                    end else if (f_is_inf(r_y) || f_is_zero(r_x)) begin
                        w_sp_res = {r_x[31] ^ r_y[31], 31'd0};
                    end else begin
                        w_sp = 1'b0;
                    end
                end
                default: w_sp = 1'b0;
            endcase
        end

        // add alignment, small operand jammed with its sticky bit
        w_xbig = !(r_x[30:0] < r_y[30:0]);
        w_mbig = w_xbig ? w_mx : w_my;
        w_msml = w_xbig ? w_my : w_mx;
        w_eb8  = w_xbig ? w_ex : w_ey;
        w_es8  = w_xbig ? w_ey : w_ex;
        w_bs   = w_xbig ? r_x[31] : w_sy;
        w_d    = w_eb8 - w_es8;
        w_ext  = {w_msml, 3'b000};
        if (w_d >= 8'd27) begin
            w_shf = 27'd0;
            w_stk = |w_ext;
        end else begin
            w_shf = w_ext >> w_d;
            w_stk = (w_shf << w_d) != w_ext;
        end
        if (r_x[31] == w_sy) begin
            w_sum = {1'b0, w_mbig, 3'b000} + {1'b0, w_shf[26:1], w_shf[0] | w_stk};
        end else begin
            w_sum = {1'b0, w_mbig, 3'b000} - {1'b0, w_shf[26:1], w_shf[0] | w_stk};
        end

        w_prod  = r_ma * r_mb;
        w_ge    = r_rem >= {1'b0, r_mb};
        w_rdiff = r_rem - {1'b0, r_mb};

        // round to nearest even
        w_mant = r_m[50:27];
        w_g    = r_m[26];
        w_st   = (|r_m[25:0]) | r_stk;
        w_inc  = w_g & (w_st | w_mant[0]);
        w_rs   = {1'b0, w_mant} + {24'd0, w_inc};
        w_rm   = w_rs[24] ? w_rs[24:1] : w_rs[23:0];
        w_re   = w_rs[24] ? r_e + 12'sd1 : r_e;
        if (!w_rm[23]) begin
            w_rnd = {r_s, 8'd0, w_rm[22:0]};
        end else if (w_re >= 12'sd255) begin
            w_rnd = {r_s, 8'hFF, 23'd0};
        end else begin
            w_rnd = {r_s, w_re[7:0], w_rm[22:0]};
        end
    end

    always_comb begin
        n_fst = r_fst;
        n_op  = r_op;
        n_x   = r_x;
        n_y   = r_y;
        n_res = r_res;
        n_s   = r_s;
        n_stk = r_stk;
        n_e   = r_e;
        n_ea  = r_ea;
        n_eb  = r_eb;
        n_m   = r_m;
        n_ma  = r_ma;
        n_mb  = r_mb;
        n_rem = r_rem;
        n_q   = r_q;
        n_cnt = r_cnt;
        unique case (r_fst)
            F_IDLE: begin
                if (i_start) begin
                    n_op  = i_op;
                    n_x   = i_x;
                    n_y   = i_y;
                    n_fst = F_SETUP;
                end
            end
            F_SETUP: begin
                if (w_sp) begin
                    n_res = w_sp_res;
                    n_fst = F_DONE;
                end else if (r_op == FOP_ADD || r_op == FOP_SUB) begin
                    if (w_sum == 28'd0) begin
                        n_res = {r_x[31] & w_sy, 31'd0};
                        n_fst = F_DONE;
                    end else begin
                        n_m   = {w_sum, 24'd0};
                        n_e   = $signed({4'd0, w_eb8});
                        n_s   = w_bs;
                        n_stk = 1'b0;
                        n_fst = F_NORM;
                    end
                end else begin
                    n_ma  = w_mx;
                    n_mb  = w_my;
                    n_ea  = $signed({4'd0, w_ex});
                    n_eb  = $signed({4'd0, w_ey});
                    n_s   = r_x[31] ^ r_y[31];
                    n_fst = F_PRE;
                end
            end
            F_PRE: begin
                // bring subnormal significands up to a leading one
                if (!r_ma[23]) begin
                    n_ma = {r_ma[22:0], 1'b0};
                    n_ea = r_ea - 12'sd1;
                end
                if (!r_mb[23]) begin
                    n_mb = {r_mb[22:0], 1'b0};
                    n_eb = r_eb - 12'sd1;
                end
                if (r_ma[23] && r_mb[23]) begin
                    if (r_op == FOP_MUL) begin
                        n_m   = {w_prod, 4'd0};
                        n_e   = r_ea + r_eb - 12'sd127;
                        n_stk = 1'b0;
                        n_fst = F_NORM;
                    end else begin
                        n_e   = r_ea - r_eb + 12'sd127;
                        n_rem = {1'b0, r_ma};
                        n_cnt = '0;
                        n_fst = F_DIV;
                    end
                end
            end
            F_DIV: begin
                n_q   = {r_q[QBITS-2:0], w_ge};
                n_rem = w_ge ? {w_rdiff[23:0], 1'b0} : {r_rem[23:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == QCW'(QBITS - 1)) begin
                    n_fst = F_DVEND;
                end
            end
            F_DVEND: begin
                n_m   = {1'b0, r_q, r_rem != 25'd0, 23'd0};
                n_stk = 1'b0;
                n_fst = F_NORM;
            end
            F_NORM: begin
                if (r_m[51]) begin
                    n_m   = {1'b0, r_m[51:1]};
                    n_stk = r_stk | r_m[0];
                    n_e   = r_e + 12'sd1;
                end else if (r_e < 12'sd1) begin
                    if (r_m == 52'd0) begin
                        n_e = 12'sd1;
                    end else begin
                        n_m   = {1'b0, r_m[51:1]};
                        n_stk = r_stk | r_m[0];
                        n_e   = r_e + 12'sd1;
                    end
                end else if (!r_m[50] && (r_m != 52'd0) && (r_e > 12'sd1)) begin
                    n_m = {r_m[50:0], 1'b0};
                    n_e = r_e - 12'sd1;
                end else begin
                    n_fst = F_ROUND;
                end
            end
            F_ROUND: begin
                n_res = w_rnd;
                n_fst = F_DONE;
            end
            F_DONE: n_fst = F_IDLE;
            default: n_fst = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fst <= F_IDLE;
        end else begin
            r_fst <= n_fst;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_x   <= n_x;
        r_y   <= n_y;
        r_res <= n_res;
        r_s   <= n_s;
        r_stk <= n_stk;
        r_e   <= n_e;
        r_ea  <= n_ea;
        r_eb  <= n_eb;
        r_m   <= n_m;
        r_ma  <= n_ma;
        r_mb  <= n_mb;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_cnt <= n_cnt;
    end

    assign o_done = (r_fst == F_DONE);
    assign o_res  = r_res;

endmodule

// ----- src/saturating_float_alu_unit.sv -----
`timescale 1ns / 1ps
// Every request first runs two multiplies by ten plus three sanitize steps; then mul, div,
// add/sub and compares run at most one float op, and sqrt up to 8 Newton steps of a divide,
// an add, a multiply by one half and a subtract. Subnormal operands stretch one float op
// (pre/post normalization). Throughput: one item at a time, next item taken the cycle after
// the result is registered; input stalls while a new result waits for the last to be taken.
// Reset (sync, active low): limits +/-1e30, epsilon 1e-6.
module saturating_float_alu_unit import sfa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    sfa_req_if.sink     i_req,
    sfa_rsp_if.source   o_rsp
);

    t_state           r_state, n_state, r_ret, n_ret;
    t_req_op          r_op, n_op;
    logic [31:0]      r_hi, n_hi, r_lo, n_lo, r_eps, n_eps;
    logic [31:0]      r_a, n_a, r_b, n_b, r_c, n_c;
    logic [31:0]      r_ca, n_ca, r_cb, n_cb, r_cc, n_cc;
    logic [31:0]      r_h, n_h, r_l, n_l, r_res, n_res, r_x, n_x;
    logic [31:0]      r_val, n_val, r_oval, n_oval;
    logic             r_truth, n_truth, r_otruth, n_otruth, r_ov, n_ov;
    logic [SQ_CW-1:0] r_cnt, n_cnt;

    logic        w_fstart, w_fdone;
    t_fop        w_fop;
    logic [31:0] w_fx, w_fy, w_fres, w_cl_in, w_cl;

    sfa_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_fstart),
        .i_op    (w_fop),
        .i_x     (w_fx),
        .i_y     (w_fy),
        .o_done  (w_fdone),
        .o_res   (w_fres)
    );

    always_comb begin
        case (r_state)
            S_CA:          w_cl_in = r_a;
            S_CB:          w_cl_in = r_b;
            S_CC:          w_cl_in = r_c;
            S_EQA:         w_cl_in = r_ca;
            S_EQB:         w_cl_in = r_cb;
            S_FINC, S_EQF: w_cl_in = r_res;
            S_SQE:         w_cl_in = r_x;
            default:       w_cl_in = r_a;
        endcase
        w_cl = f_clean(w_cl_in, r_hi, r_lo, r_eps, r_h, r_l);
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_op     = r_op;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_eps    = r_eps;
        n_a      = r_a;
        n_b      = r_b;
        n_c      = r_c;
        n_ca     = r_ca;
        n_cb     = r_cb;
        n_cc     = r_cc;
        n_h      = r_h;
        n_l      = r_l;
        n_res    = r_res;
        n_x      = r_x;
        n_val    = r_val;
        n_truth  = r_truth;
        n_oval   = r_oval;
        n_otruth = r_otruth;
        n_cnt    = r_cnt;
        n_ov     = r_ov && !o_rsp.ready;
        w_fstart = 1'b0;
        w_fop    = FOP_ADD;
        w_fx     = r_ca;
        w_fy     = r_cb;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_UPPER: n_hi  = i_cfg_wdata;
                CFG_LOWER: n_lo  = i_cfg_wdata;
                CFG_EPS:   n_eps = i_cfg_wdata;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = t_req_op'(i_req.req_type);
                    n_a     = i_req.operand_a;
                    n_b     = i_req.operand_b;
                    n_c     = i_req.operand_c;
                    n_state = S_H;
                end
            end
            S_H: begin
                w_fstart = 1'b1;
                w_fop    = FOP_MUL;
                w_fx     = r_hi;
                w_fy     = F_TEN;
                n_ret    = S_L;
                n_state  = S_WAIT;
            end
            S_L: begin
                n_h      = r_res;
                w_fstart = 1'b1;
                w_fop    = FOP_MUL;
                w_fx     = r_lo;
                w_fy     = F_TEN;
                n_ret    = S_LSV;
                n_state  = S_WAIT;
            end
            S_LSV: begin
                n_l     = r_res;
                n_state = S_CA;
            end
            S_CA: begin
                n_ca    = w_cl;
                n_state = S_CB;
            end
            S_CB: begin
                n_cb    = w_cl;
                n_state = S_CC;
            end
            S_CC: begin
                n_cc    = w_cl;
                n_state = S_DISP;
            end
            S_DISP: begin
                n_val   = F_ZERO;
                n_truth = 1'b0;
                n_state = S_OUT;
                unique case (r_op)
                    OP_ADD, OP_SUB: begin
                        w_fstart = 1'b1;
                        w_fop    = (r_op == OP_ADD) ? FOP_ADD : FOP_SUB;
                        n_ret    = S_FINC;
                        n_state  = S_WAIT;
                    end
                    OP_MUL, OP_SQUARE: begin
                        w_fy = (r_op == OP_SQUARE) ? r_ca : r_cb;
                        if (!f_near_zero(r_ca, r_eps) && !f_near_zero(w_fy, r_eps)) begin
                            w_fstart = 1'b1;
                            w_fop    = FOP_MUL;
                            n_ret    = S_FINS;
                            n_state  = S_WAIT;
                        end
                    end
                    OP_DIV: begin
                        if (!f_near_zero(r_cb, r_eps) && !f_eq(r_cb, F_ZERO) &&
                            !f_near_zero(r_ca, r_eps)) begin
                            w_fstart = 1'b1;
                            w_fop    = FOP_DIV;
                            n_ret    = S_FINS;
                            n_state  = S_WAIT;
                        end
                    end
                    OP_SQRT: begin
                        if (!(f_lt(r_ca, F_ZERO) || f_eq(r_ca, F_ZERO)) &&
                            !f_lt(r_ca, r_eps)) begin
                            n_x     = r_ca;
                            n_cnt   = '0;
                            n_state = S_SQT;
                        end
                    end
                    OP_MIN: n_val = f_lt(r_ca, r_cb) ? r_ca : r_cb;
                    OP_MAX: n_val = f_lt(r_cb, r_ca) ? r_ca : r_cb;
                    OP_CLAMP: begin
                        if (f_lt(r_ca, r_cb)) begin
                            n_val = r_cb;
                        end else if (f_lt(r_cc, r_ca)) begin
                            n_val = r_cc;
                        end else begin
                            n_val = r_ca;
                        end
                    end
                    OP_ABS: n_val = f_lt(r_a, F_ZERO) ? {~r_a[31], r_a[30:0]} : r_a;
                    OP_SANITIZE: n_val = r_ca;
                    OP_IS_SAFE: begin
                        n_truth = !f_is_nan(r_a) && !f_lt(r_h, r_a) && !f_lt(r_a, r_l) &&
                                  !f_lt(r_hi, r_a) && !f_lt(r_a, r_lo);
                    end
                    OP_IS_ZERO: n_truth = f_near_zero(r_a, r_eps);
                    OP_EQ: n_state = S_EQA;
                    OP_LT, OP_GE: begin
                        w_fstart = 1'b1;
                        w_fop    = FOP_SUB;
                        w_fx     = r_cb;
                        w_fy     = r_eps;
                        n_ret    = S_CMPF;
                        n_state  = S_WAIT;
                    end
                    OP_LE, OP_GT: begin
                        w_fstart = 1'b1;
                        w_fop    = FOP_ADD;
                        w_fx     = r_cb;
                        w_fy     = r_eps;
                        n_ret    = S_CMPF;
                        n_state  = S_WAIT;
                    end
                    default: ;
                endcase
            end
            S_WAIT: begin
                if (w_fdone) begin
                    n_res   = w_fres;
                    n_state = r_ret;
                end
            end
            S_FINC: begin
                n_val   = w_cl;
                n_state = S_OUT;
            end
            S_FINS: begin
                n_val   = f_sat(r_res, r_hi, r_lo, r_eps);
                n_state = S_OUT;
            end
            // equality sanitizes its operands a second time
            S_EQA: begin
                n_ca    = w_cl;
                n_state = S_EQB;
            end
            S_EQB: begin
                n_cb    = w_cl;
                n_state = S_EQS;
            end
            S_EQS: begin
                w_fstart = 1'b1;
                w_fop    = FOP_SUB;
                n_ret    = S_EQF;
                n_state  = S_WAIT;
            end
            S_EQF: begin
                n_val   = F_ZERO;
                n_truth = f_lt({1'b0, w_cl[30:0]}, r_eps);
                n_state = S_OUT;
            end
            S_CMPF: begin
                n_val = F_ZERO;
                case (r_op)
                    OP_LT:   n_truth = f_lt(r_ca, r_res);
                    OP_LE:   n_truth = f_lt(r_ca, r_res) || f_eq(r_ca, r_res);
                    OP_GT:   n_truth = f_lt(r_res, r_ca);
                    default: n_truth = f_lt(r_res, r_ca) || f_eq(r_ca, r_res);
                endcase
                n_state = S_OUT;
            end
            // Newton step: est = (est + x / est) * 0.5
            S_SQT: begin
                if ((r_cnt == SQ_CW'(SQRT_STEPS)) || f_lt(r_x, r_eps) ||
                    f_eq(r_x, F_ZERO)) begin
                    n_state = S_SQE;
                end else begin
                    w_fstart = 1'b1;
                    w_fop    = FOP_DIV;
                    w_fx     = r_ca;
                    w_fy     = r_x;
                    n_ret    = S_SQADD;
                    n_state  = S_WAIT;
                end
            end
            S_SQADD: begin
                w_fstart = 1'b1;
                w_fop    = FOP_ADD;
                w_fx     = r_x;
                w_fy     = r_res;
                n_ret    = S_SQHALF;
                n_state  = S_WAIT;
            end
            S_SQHALF: begin
                w_fstart = 1'b1;
                w_fop    = FOP_MUL;
                w_fx     = r_res;
                w_fy     = F_HALF;
                n_ret    = S_SQDIFF;
                n_state  = S_WAIT;
            end
            S_SQDIFF: begin
                n_x      = r_res;
                w_fstart = 1'b1;
                w_fop    = FOP_SUB;
                w_fx     = r_res;
                w_fy     = r_x;
                n_ret    = S_SQCHK;
                n_state  = S_WAIT;
            end
            S_SQCHK: begin
                if (f_lt({1'b0, r_res[30:0]}, r_eps)) begin
                    n_state = S_SQE;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_SQT;
                end
            end
            S_SQE: begin
                n_val   = w_cl;
                n_truth = 1'b0;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov     = 1'b1;
                    n_oval   = r_val;
                    n_otruth = r_truth;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_hi    <= UPPER_RST;
            r_lo    <= LOWER_RST;
            r_eps   <= EPS_RST;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_hi    <= n_hi;
            r_lo    <= n_lo;
            r_eps   <= n_eps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret    <= n_ret;
        r_op     <= n_op;
        r_a      <= n_a;
        r_b      <= n_b;
        r_c      <= n_c;
        r_ca     <= n_ca;
        r_cb     <= n_cb;
        r_cc     <= n_cc;
        r_h      <= n_h;
        r_l      <= n_l;
        r_res    <= n_res;
        r_x      <= n_x;
        r_val    <= n_val;
        r_truth  <= n_truth;
        r_oval   <= n_oval;
        r_otruth <= n_otruth;
        r_cnt    <= n_cnt;
    end

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_ov;
    assign o_rsp.value_out = r_oval;
    assign o_rsp.truth_out = r_otruth;

endmodule
